>>> sv/clpi_pkg.sv
// types and constants shared by the line pair crossing block
`timescale 1ns / 1ps
package clpi_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

    localparam logic [CFG_DATA_W-1:0] IMAGE_ROWS_RESET = 13'd480;
    localparam logic [CFG_DATA_W-1:0] IMAGE_COLS_RESET = 13'd640;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         line_index;
        logic [3:0]         other_index;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic               vertical_flag;
        logic [11:0]        x_min;
        logic [11:0]        x_max;
        logic [11:0]        y_min;
        logic [11:0]        y_max;
    } t_req;

    typedef struct packed {
        logic signed [31:0] x_cross;
        logic signed [31:0] y_cross;
        logic               found_flag;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic               vertical;
        logic [11:0]        x_min;
        logic [11:0]        x_max;
        logic [11:0]        y_min;
        logic [11:0]        y_max;
    } t_line;

endpackage

>>> sv/clipped_line_pair_intersection.sv
// top level: line table and crossing point of two stored lines
//
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_ready    | t_req: store a line or query a pair
//  out     | output    | o_out_valid / i_out_ready  | t_rsp: crossing point, one per query
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | register index and 13 bit value
//
//  a store writes the table in the cycle it is accepted and the block is ready again on the next
//  a query of two sloped lines runs through two table reads, setup,
//  49 steps of the one bit per cycle divider, then quotient, multiply, add and check
//  a query with one vertical line skips the divider, a rejected pair goes from setup to the check
//  the table holds no valid state, so no clearing pass follows reset
//  a full output register holds the finished query until the word is taken
`timescale 1ns / 1ps
module clipped_line_pair_intersection #(
    parameter int MAX_LINES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  clpi_pkg::t_req                 i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output clpi_pkg::t_rsp                 o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [clpi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clpi_pkg::*;

    localparam int AW = $clog2(MAX_LINES);
    localparam logic [6:0] MaxLines = 7'(MAX_LINES);
    localparam logic [5:0] DivSteps = 6'd48;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDC  = 4'd2;
    localparam logic [3:0] S_PREP = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_QUO  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;

    logic [3:0]  r_state, n_state;
    logic        r_out_valid;
    t_rsp        r_out;
    logic [CFG_DATA_W-1:0] r_rows, r_cols;

    logic [3:0]  r_idx_a, r_idx_c;
    t_line       r_la, r_lc;
    logic        r_have;
    logic signed [31:0] r_x, r_ms, r_bs, r_y;
    logic signed [63:0] r_prod;
    logic [48:0] r_dvd;
    logic [32:0] r_dvs;
    logic [32:0] r_rem;
    logic        r_neg;
    logic [5:0]  r_cnt;

    logic        in_acc, out_free;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [6:0]  wide_a, wide_c, wide_in, wide_rd;
    t_line       wr_line, rd_line;
    logic [$bits(t_line)-1:0] rd_data;

    logic        pair_ok, v1, v2, have_c;
    logic signed [32:0] diff, dm;
    logic [32:0] diff_mag, dm_mag;
    logic [33:0] rem_sh;
    logic        q_bit;
    logic signed [31:0] x_quo;
    logic signed [47:0] prod_sh;
    logic signed [48:0] y_sum;
    logic signed [31:0] y_sat;
    logic [31:0] ux, uy, cols_q, rows_q;
    logic        found;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // table access
    assign wide_in = {3'b0, i_in_word.line_index};
    assign wide_a  = {3'b0, r_idx_a};
    assign wide_c  = {3'b0, r_idx_c};
    assign wr_en   = in_acc && (i_in_word.req_type == REQ_STORE) && (wide_in < MaxLines);
    assign wr_addr = wide_in[AW-1:0];
    assign wide_rd = (r_state == S_IDLE) ? wide_in : wide_c;
    assign rd_addr = wide_rd[AW-1:0];

    always_comb begin
        wr_line.slope     = i_in_word.slope;
        wr_line.intercept = i_in_word.intercept;
        wr_line.vertical  = i_in_word.vertical_flag;
        wr_line.x_min     = i_in_word.x_min;
        wr_line.x_max     = i_in_word.x_max;
        wr_line.y_min     = i_in_word.y_min;
        wr_line.y_max     = i_in_word.y_max;
    end

    clpi_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_LINES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_line),
        .i_rd_en   (1'b1),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_line = t_line'(rd_data);

    // pair setup
    assign pair_ok  = (wide_a < MaxLines) && (wide_c < MaxLines) && (r_idx_a != r_idx_c);
    assign v1       = r_la.vertical;
    assign v2       = r_lc.vertical;
    assign diff     = {r_lc.intercept[31], r_lc.intercept} - {r_la.intercept[31], r_la.intercept};
    assign dm       = {r_la.slope[31], r_la.slope} - {r_lc.slope[31], r_lc.slope};
    assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;
    assign dm_mag   = dm[32] ? (~dm + 33'd1) : dm;
    assign have_c   = pair_ok && ((v1 != v2) || (!v1 && !v2 && (dm != 33'sd0)));

    // divider step
    assign rem_sh = {r_rem, r_dvd[48]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvs});

    // quotient sign and saturation
    always_comb begin
        if (!r_neg) begin
            x_quo = (r_dvd > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_dvd[31:0]);
        end else begin
            x_quo = (r_dvd > 49'h0_8000_0000) ? 32'sh8000_0000
                                              : $signed(~r_dvd[31:0] + 32'd1);
        end
    end

    // floor shift, add intercept, saturate
    assign prod_sh = r_prod[63:16];
    assign y_sum   = {prod_sh[47], prod_sh} + {{17{r_bs[31]}}, r_bs};
    always_comb begin
        if ((&y_sum[48:31]) || !(|y_sum[48:31])) begin
            y_sat = y_sum[31:0];
        end else if (y_sum[48]) begin
            y_sat = 32'sh8000_0000;
        end else begin
            y_sat = 32'sh7FFF_FFFF;
        end
    end

    // window checks
    assign ux     = r_x;
    assign uy     = r_y;
    assign cols_q = {3'b0, r_cols, 16'b0};
    assign rows_q = {3'b0, r_rows, 16'b0};
    assign found  = r_have && !r_x[31] && !r_y[31] && (ux < cols_q) && (uy < rows_q)
                 && (ux >= {4'b0, r_la.x_min, 16'b0}) && (ux <= {4'b0, r_la.x_max, 16'b0})
                 && (ux >= {4'b0, r_lc.x_min, 16'b0}) && (ux <= {4'b0, r_lc.x_max, 16'b0})
                 && (uy >= {4'b0, r_la.y_min, 16'b0}) && (uy <= {4'b0, r_la.y_max, 16'b0})
                 && (uy >= {4'b0, r_lc.y_min, 16'b0}) && (uy <= {4'b0, r_lc.y_max, 16'b0});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_word.req_type == REQ_QUERY)) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: n_state = S_RDC;
            S_RDC: n_state = S_PREP;
            S_PREP: begin
                if (!have_c) begin
                    n_state = S_CHK;
                end else if (!v1 && !v2) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'd0) begin
                    n_state = S_QUO;
                end
            end
            S_QUO: n_state = S_MUL;
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_CHK;
            S_CHK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rows      <= IMAGE_ROWS_RESET;
            r_cols      <= IMAGE_COLS_RESET;
        end else begin
            r_state <= n_state;
            if ((r_state == S_CHK) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_ROWS: r_rows <= i_cfg_data;
                    CFG_IMAGE_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx_a <= i_in_word.line_index;
                r_idx_c <= i_in_word.other_index;
            end
            S_RDA: r_la <= rd_line;
            S_RDC: r_lc <= rd_line;
            S_PREP: begin
                r_have <= have_c;
                r_dvd  <= {diff_mag, 16'b0};
                r_dvs  <= dm_mag;
                r_rem  <= 33'd0;
                r_neg  <= diff[32] ^ dm[32];
                r_cnt  <= DivSteps;
                if (v1) begin
                    r_x  <= r_la.intercept;
                    r_ms <= r_lc.slope;
                    r_bs <= r_lc.intercept;
                end else if (v2) begin
                    r_x  <= r_lc.intercept;
                    r_ms <= r_la.slope;
                    r_bs <= r_la.intercept;
                end else begin
                    r_ms <= r_la.slope;
                    r_bs <= r_la.intercept;
                end
            end
            S_DIV: begin
                r_rem <= q_bit ? 33'(rem_sh - {1'b0, r_dvs}) : rem_sh[32:0];
                r_dvd <= {r_dvd[47:0], q_bit};
                r_cnt <= r_cnt - 6'd1;
            end
            S_QUO: r_x <= x_quo;
            S_MUL: r_prod <= r_ms * r_x;
            S_ADD: r_y <= y_sat;
            S_CHK: begin
                if (out_free) begin
                    r_out.found_flag <= found;
                    r_out.x_cross    <= found ? r_x : 32'sd0;
                    r_out.y_cross    <= found ? r_y : 32'sd0;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/clpi_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module clpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/clpi_checker.sv
// port level checks for the line pair crossing block, bound to the top level
`timescale 1ns / 1ps
module clpi_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  clpi_pkg::t_req                  i_in_word,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  clpi_pkg::t_rsp                  o_out_word,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [clpi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clpi_pkg::*;

    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // no crossing means a zero point
    a_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found_flag |->
            (o_out_word.x_cross == 32'sd0) && (o_out_word.y_cross == 32'sd0))
        else $error("point not zero without a crossing");

    // a found point has no negative coordinate
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.found_flag |->
            !o_out_word.x_cross[31] && !o_out_word.y_cross[31])
        else $error("found point negative");

    // a store finishes at once
    a_store_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.req_type == REQ_STORE) |=> o_in_ready)
        else $error("store did not return to ready");

    // a query occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.req_type == REQ_QUERY) |=> !o_in_ready)
        else $error("ready during query");

endmodule

bind clipped_line_pair_intersection clpi_checker u_clpi_checker (.*);
